@@ design/asgp_pkg.sv @@
// ----------------------------------------------------------------------------
// asgp_pkg
// Shared sizes, item types and the job store request for the gap placer.
// ----------------------------------------------------------------------------
package asgp_pkg;

    // Table sizes
    localparam int MAX_JOBS            = 64;
    localparam int MAX_MACHINES        = 16;
    localparam int MAX_OPS_PER_MACHINE = 64;

    // Derived widths
    localparam int JOB_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int MACH_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int OPS_W  = (MAX_OPS_PER_MACHINE > 1) ? $clog2(MAX_OPS_PER_MACHINE) : 1;
    localparam int CNT_W  = $clog2(MAX_OPS_PER_MACHINE + 1);
    localparam int TBL_DEPTH = MAX_MACHINES * MAX_OPS_PER_MACHINE;
    localparam int TBL_AW = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int TIME_W = 32;

    // One operation to place
    typedef struct packed {
        logic        new_schedule;
        logic [5:0]  job_index;
        logic [3:0]  machine_index;
        logic [15:0] processing_time;
    } op_t;

    // One placement result
    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic [31:0] makespan;
        logic        overflow;
    } result_t;

    // Request to the job end store
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [JOB_W-1:0]  rd_addr;
        logic              wr_en;
        logic [JOB_W-1:0]  wr_addr;
        logic [TIME_W-1:0] wr_data;
    } job_req_t;

endpackage

@@ design/asgp_job_store.sv @@
// ----------------------------------------------------------------------------
// asgp_job_store
// End time of each job's latest operation: a synchronous memory with one
// valid bit per entry, so that a new schedule clears every job at once.
// ----------------------------------------------------------------------------
module asgp_job_store (
    input  logic                             clk,
    input  logic                             rst_n,
    input  asgp_pkg::job_req_t               req,
    output logic [asgp_pkg::TIME_W-1:0]      rd_data
);

    logic [asgp_pkg::TIME_W-1:0]   mem [asgp_pkg::MAX_JOBS];
    logic [asgp_pkg::MAX_JOBS-1:0] valid_reg;
    logic [asgp_pkg::TIME_W-1:0]   rd_reg;
    logic                          hit_reg;

    // Write and read the memory, registered read data
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_reg <= mem[req.rd_addr];
        end
    end

    // Track written entries; drop them all on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // An entry not written in this schedule reads as zero
    assign rd_data = hit_reg ? rd_reg : '0;

endmodule

@@ design/active_schedule_gap_placer_top.sv @@
// ----------------------------------------------------------------------------
// active_schedule_gap_placer_top
// Places operations into the earliest idle gap of their machine.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op and raise start; the item is taken at the edge where start is
//   high and busy is low. busy stays high until the result is shown and
//   falls in the cycle that carries it.
//   The result appears on result for exactly one cycle with done high; the
//   receiver cannot stall and must take it in that cycle.
//   Steps: after the check and the release read an item scans its
//   machine for the earliest gap, shifts up the intervals that start no
//   earlier and is put in, with at most one scan step and one shift step
//   per stored interval, through the single read port of the interval
//   table; on an empty machine both are skipped. A dropped item (full
//   machine, bad index) ends after the check, a time overflow before placing.
//   Throughput: one item at a time; the next can be taken at the edge that
//   ends the done cycle.
//   Reset: clears job ends, interval counts and makespan; the interval
//   table itself needs no clearing since only counted entries are read.
//   new_schedule on an item clears the same state before it is placed.
// ----------------------------------------------------------------------------
module active_schedule_gap_placer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  asgp_pkg::op_t      op,
    output logic               busy,
    output logic               done,
    output asgp_pkg::result_t  result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_REL   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;
    localparam logic [2:0] ST_INS   = 3'd5;
    localparam logic [2:0] ST_PUT   = 3'd6;

    localparam int CW = asgp_pkg::CNT_W;
    localparam int OW = asgp_pkg::OPS_W;
    localparam int TW = asgp_pkg::TIME_W;
    localparam int AW = asgp_pkg::TBL_AW;

    // Control state
    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg [asgp_pkg::MAX_MACHINES];
    logic [CW-1:0]         count_wr_val;
    logic                  count_wr;
    logic                  count_clr;
    logic [TW-1:0]         makespan_reg, makespan_next;
    logic                  done_reg, done_next;

    // Item payload
    asgp_pkg::op_t         op_reg;
    logic [OW-1:0]         idx_reg, idx_next;
    logic [TW-1:0]         prev_end_reg, prev_end_next;
    logic [TW-1:0]         start_reg, start_next;
    logic [TW-1:0]         end_reg, end_next;
    asgp_pkg::result_t     result_reg, result_next;

    // Interval table: {start, end} per slot
    logic [2*TW-1:0]       tbl_mem [asgp_pkg::TBL_DEPTH];
    logic [2*TW-1:0]       tbl_rd_reg;
    logic [AW-1:0]         tbl_ra;
    logic [AW-1:0]         tbl_wa;
    logic [2*TW-1:0]       tbl_wd;
    logic                  tbl_we;

    // Job store
    asgp_pkg::job_req_t    job_req;
    logic [TW-1:0]         job_rel;

    // Datapath
    logic [asgp_pkg::MACH_W-1:0] mach_sel;
    logic [CW-1:0]         cur_cnt;
    logic                  in_range;
    logic                  accept;
    logic [TW-1:0]         ivl_start;
    logic [TW-1:0]         ivl_end;
    logic [TW-1:0]         gap;
    logic                  fit;
    logic [TW-1:0]         pe_upd;
    logic [TW-1:0]         tail_start;
    logic                  last_scan;
    logic [TW:0]           end_sum;

    // Slot address of one machine's interval
    function automatic logic [AW-1:0] slot_addr(
        input logic [asgp_pkg::MACH_W-1:0] mach,
        input logic [OW-1:0]               idx
    );
        logic [AW-1:0] base;
        base = AW'(mach) * AW'(asgp_pkg::MAX_OPS_PER_MACHINE);
        return base + AW'(idx);
    endfunction

    asgp_job_store u_job_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (job_req),
        .rd_data (job_rel)
    );

    // Interval table memory
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        tbl_rd_reg <= tbl_mem[tbl_ra];
    end

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    assign mach_sel  = asgp_pkg::MACH_W'(op_reg.machine_index);
    assign cur_cnt   = count_reg[mach_sel];
    assign in_range  = (int'(op_reg.job_index) < asgp_pkg::MAX_JOBS) &&
                       (int'(op_reg.machine_index) < asgp_pkg::MAX_MACHINES);

    // Gap test on the interval just read
    assign ivl_start  = tbl_rd_reg[2*TW-1:TW];
    assign ivl_end    = tbl_rd_reg[TW-1:0];
    assign gap        = (job_rel > prev_end_reg) ? job_rel : prev_end_reg;
    assign fit        = ({1'b0, gap} + (TW+1)'(op_reg.processing_time)) <= {1'b0, ivl_start};
    assign pe_upd     = (ivl_end > prev_end_reg) ? ivl_end : prev_end_reg;
    assign tail_start = (job_rel > pe_upd) ? job_rel : pe_upd;
    assign last_scan  = (CW'(idx_reg) == (cur_cnt - CW'(1)));
    assign end_sum    = {1'b0, start_reg} + (TW+1)'(op_reg.processing_time);

    // Sequence one item: check, release, scan, place, shift in
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        prev_end_next = prev_end_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        makespan_next = makespan_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        count_wr      = 1'b0;
        count_wr_val  = cur_cnt + CW'(1);
        count_clr     = 1'b0;
        tbl_ra        = slot_addr(mach_sel, idx_reg);
        tbl_we        = 1'b0;
        tbl_wa        = slot_addr(mach_sel, idx_reg + OW'(1));
        tbl_wd        = {start_reg, end_reg};
        job_req       = '0;
        job_req.rd_addr = asgp_pkg::JOB_W'(op_reg.job_index);
        job_req.wr_addr = asgp_pkg::JOB_W'(op_reg.job_index);
        job_req.wr_data = end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op.new_schedule)
                    begin
                        count_clr     = 1'b1;
                        makespan_next = '0;
                        job_req.clear = 1'b1;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Drop on bad index or a full machine
                if (!in_range || (cur_cnt >= CW'(asgp_pkg::MAX_OPS_PER_MACHINE)))
                begin
                    result_next = '{start_time: '0, end_time: '0,
                                    makespan: makespan_reg, overflow: 1'b1};
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    job_req.rd_en = 1'b1;
                    idx_next      = '0;
                    prev_end_next = '0;
                    state_next    = ST_REL;
                end
            end
            ST_REL:
            begin
                // Release is valid; first interval read goes out now
                if (cur_cnt == '0)
                begin
                    start_next = job_rel;
                    state_next = ST_END;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                tbl_ra = slot_addr(mach_sel, idx_reg + OW'(1));
                if (fit)
                begin
                    start_next = gap;
                    state_next = ST_END;
                end
                else if (last_scan)
                begin
                    start_next = tail_start;
                    state_next = ST_END;
                end
                else
                begin
                    prev_end_next = pe_upd;
                    idx_next      = idx_reg + OW'(1);
                end
            end
            ST_END:
            begin
                idx_next = OW'(cur_cnt - CW'(1));
                tbl_ra   = slot_addr(mach_sel, OW'(cur_cnt - CW'(1)));
                end_next = end_sum[TW-1:0];
                if (end_sum[TW])
                begin
                    result_next = '{start_time: '0, end_time: '0,
                                    makespan: makespan_reg, overflow: 1'b1};
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    job_req.wr_en   = 1'b1;
                    job_req.wr_data = end_sum[TW-1:0];
                    if (end_sum[TW-1:0] > makespan_reg)
                    begin
                        makespan_next = end_sum[TW-1:0];
                    end
                    if (cur_cnt == '0)
                    begin
                        // Empty machine: place at the first slot
                        tbl_we      = 1'b1;
                        tbl_wa      = slot_addr(mach_sel, '0);
                        tbl_wd      = {start_reg, end_sum[TW-1:0]};
                        count_wr    = 1'b1;
                        result_next = '{start_time: start_reg, end_time: end_sum[TW-1:0],
                                        makespan: makespan_next, overflow: 1'b0};
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_INS;
                    end
                end
            end
            ST_INS:
            begin
                // Walk down from the top, shifting intervals that start no earlier
                tbl_ra = slot_addr(mach_sel, idx_reg - OW'(1));
                tbl_we = 1'b1;
                if (ivl_start >= start_reg)
                begin
                    tbl_wd = tbl_rd_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        idx_next = idx_reg - OW'(1);
                    end
                end
                else
                begin
                    count_wr    = 1'b1;
                    result_next = '{start_time: start_reg, end_time: end_reg,
                                    makespan: makespan_reg, overflow: 1'b0};
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_PUT:
            begin
                tbl_we      = 1'b1;
                tbl_wa      = slot_addr(mach_sel, '0);
                count_wr    = 1'b1;
                result_next = '{start_time: start_reg, end_time: end_reg,
                                makespan: makespan_reg, overflow: 1'b0};
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            makespan_reg <= '0;
            done_reg     <= 1'b0;
            for (int m = 0; m < asgp_pkg::MAX_MACHINES; m++)
            begin
                count_reg[m] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            makespan_reg <= makespan_next;
            done_reg     <= done_next;
            if (count_clr)
            begin
                for (int m = 0; m < asgp_pkg::MAX_MACHINES; m++)
                begin
                    count_reg[m] <= '0;
                end
            end
            else if (count_wr)
            begin
                count_reg[mach_sel] <= count_wr_val;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op;
        end
        idx_reg      <= idx_next;
        prev_end_reg <= prev_end_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        result_reg   <= result_next;
    end

endmodule

@@ design/asgp_checker.sv @@
// ----------------------------------------------------------------------------
// asgp_checker
// Port-level checks on the gap placer's command and result channels.
// ----------------------------------------------------------------------------
module asgp_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               done,
    input  asgp_pkg::result_t  result
);

    // Taken item keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // Result only after a busy cycle, and the block is free with it
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result without preceding work");

    // Dropped item carries zero times
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> (result.start_time == '0 && result.end_time == '0))
        else $error("dropped item with non-zero times");

    // Placed item ends no earlier than it starts and within the makespan
    a_place_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.overflow) |->
            (result.end_time >= result.start_time && result.makespan >= result.end_time))
        else $error("placed item times inconsistent");

endmodule

bind active_schedule_gap_placer_top asgp_checker u_asgp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
